FILE: hw/rtl/lllf_pkg.sv
// Package with the constants and types shared by the lead-lag filter.
package lllf_pkg;

  // Counter modulus for the tick counter.
  localparam int unsigned COUNT_MODULUS = 10000;
  localparam int unsigned CNT_W         = $clog2(COUNT_MODULUS);
  localparam int unsigned TICK_W        = 14;

  // Field and register widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Sequencer datapath widths.
  localparam int unsigned ACC_W  = 92;           // signed numerator accumulator
  localparam int unsigned MULR_W = TIME_W + 1;   // serial multiplier operand
  localparam int unsigned DEN_W  = TIME_W + 1 + 16;
  localparam int unsigned BCNT_W = 6;

  // Tick period used when the period register holds zero.
  localparam logic [TIME_W-1:0] DEFAULT_PERIOD_US = TIME_W'(1000000);

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  // Saturation limits.
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAG_TIME    = 3'd0,
    CFG_LEAD_TIME   = 3'd1,
    CFG_GAIN        = 3'd2,
    CFG_PERIOD      = 3'd3,
    CFG_RESET_VALUE = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_ROUND,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_e;

  // Passes of the shared shift-add multiplier.
  typedef enum logic [1:0] {
    PH_LEAD,   // (T+TD) * u
    PH_PREV,   // minus TD * previous input
    PH_GAIN,   // Kp * difference
    PH_LAG     // plus T1 * previous output * 2^16
  } phase_e;

endpackage

FILE: hw/rtl/lead_lag_first_order_filter.sv
// First-order lead-lag filter with a bit-serial multiply and divide sequencer.
//
// One transfer on the input channel is one control tick. An enabled tick that is not
// in reset computes out = (T1*prev_out + Kp*(T+TD)*in - Kp*TD*prev_in) / (T+T1)
// exactly, rounds once to nearest with ties away from zero and saturates to the
// signed 32-bit range. A single shift-add multiplier consumes one multiplier bit per
// cycle in four passes, then the numerator is made positive and rounded, checked for
// overflow and divided by a restoring divider that produces one quotient bit per
// cycle, and the output register is then loaded. A disabled tick or a tick in reset
// goes straight to the output register load. The input takes no new tick until the
// last one has been loaded into the output register. The output register lets the
// next tick be taken while a result still waits for its transfer; a finished tick
// then waits until that register is free, and the input stays stalled meanwhile.
// Configuration writes are expected only while idle.
module lead_lag_first_order_filter
  import lllf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DATA_W-1:0] sample_in_i,
  input  logic                 enable_i,
  input  logic                 hold_reset_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DATA_W-1:0] filter_out_o,
  output logic                 enabled_out_o,
  output logic [TICK_W-1:0]    tick_count_o
);

  // Configuration registers.
  logic [TIME_W-1:0] lag_time_q;
  logic [TIME_W-1:0] lead_time_q;
  logic [GAIN_W-1:0] gain_q;
  logic [TIME_W-1:0] period_q;
  logic [DATA_W-1:0] reset_value_q;

  // Filter state.
  logic [DATA_W-1:0] prev_in_q, prev_in_d;
  logic [DATA_W-1:0] prev_out_q, prev_out_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Sequencer control.
  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic                out_valid_q, out_valid_d;

  // Datapath registers.
  logic [DATA_W-1:0]   u_q, u_d;
  logic                en_q, en_d;
  logic                calc_q, calc_d;
  logic [DATA_W-1:0]   byp_q, byp_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [ACC_W-1:0]    mcand_q, mcand_d;
  logic [MULR_W-1:0]   mplier_q, mplier_d;
  logic                sub_q, sub_d;
  logic                msb_neg_q, msb_neg_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic                neg_q, neg_d;
  logic                ovf_q, ovf_d;
  logic [DEN_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]   quo_q, quo_d;
  logic [DATA_W-1:0]   out_q, out_d;
  logic                out_en_q, out_en_d;
  logic [TICK_W-1:0]   out_tick_q, out_tick_d;

  // Combinational helpers.
  logic [TIME_W-1:0]   t_eff;
  logic                in_xfer;
  logic                last_bit;
  logic                do_sub;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    acc_step;
  logic [DEN_W:0]      rem_shift;
  logic [DEN_W:0]      rem_diff;
  logic                rem_ge;
  logic [DATA_W-1:0]   sat_val;

  assign t_eff      = (period_q == '0) ? DEFAULT_PERIOD_US : period_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;

  // One step of the shift-add multiplier. The top multiplier bit of the gain pass
  // carries negative weight, which turns its add into a subtract.
  assign last_bit = (bcnt_q == BCNT_W'(1));
  assign do_sub   = sub_q ^ (last_bit & msb_neg_q);
  assign addend   = mplier_q[0] ? mcand_q : '0;
  assign acc_step = do_sub ? (acc_q - addend) : (acc_q + addend);

  // One step of the restoring divider.
  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_q};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});

  // Saturation and sign of the final quotient.
  always_comb begin
    if (ovf_q || quo_q[DATA_W-1]) begin
      sat_val = neg_q ? SAT_MIN : SAT_MAX;
    end else begin
      sat_val = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
    end
  end

  // Next state and datapath.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    bcnt_d      = bcnt_q;
    out_valid_d = out_valid_q;
    u_d         = u_q;
    en_d        = en_q;
    calc_d      = calc_q;
    byp_d       = byp_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    sub_d       = sub_q;
    msb_neg_d   = msb_neg_q;
    den_d       = den_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_d       = out_q;
    out_en_d    = out_en_q;
    out_tick_d  = out_tick_q;
    prev_in_d   = prev_in_q;
    prev_out_d  = prev_out_q;
    cnt_d       = cnt_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          u_d    = sample_in_i;
          en_d   = enable_i;
          calc_d = enable_i & ~hold_reset_i;
          byp_d  = enable_i ? reset_value_q : prev_out_q;
          cnt_d  = (cnt_q == CNT_W'(COUNT_MODULUS - 1)) ? '0 : cnt_q + CNT_W'(1);
          den_d  = {({1'b0, t_eff} + {1'b0, lag_time_q}), 16'b0};
          // First pass: (T+TD) times the new sample.
          acc_d     = '0;
          mcand_d   = {{(ACC_W-DATA_W){sample_in_i[DATA_W-1]}}, sample_in_i};
          mplier_d  = {1'b0, t_eff} + {1'b0, lead_time_q};
          bcnt_d    = BCNT_W'(MULR_W);
          sub_d     = 1'b0;
          msb_neg_d = 1'b0;
          phase_d   = PH_LEAD;
          state_d   = (enable_i && !hold_reset_i) ? ST_MUL : ST_OUT;
        end
      end

      ST_MUL: begin
        acc_d    = acc_step;
        mcand_d  = {mcand_q[ACC_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[MULR_W-1:1]};
        bcnt_d   = bcnt_q - BCNT_W'(1);
        if (last_bit) begin
          unique case (phase_q)
            PH_LEAD: begin
              mcand_d   = {{(ACC_W-DATA_W){prev_in_q[DATA_W-1]}}, prev_in_q};
              mplier_d  = {1'b0, lead_time_q};
              bcnt_d    = BCNT_W'(TIME_W);
              sub_d     = 1'b1;
              msb_neg_d = 1'b0;
              phase_d   = PH_PREV;
            end
            PH_PREV: begin
              // The difference becomes the multiplicand of the gain pass.
              acc_d     = '0;
              mcand_d   = acc_step;
              mplier_d  = {{(MULR_W-GAIN_W){gain_q[GAIN_W-1]}}, gain_q};
              bcnt_d    = BCNT_W'(GAIN_W);
              sub_d     = 1'b0;
              msb_neg_d = 1'b1;
              phase_d   = PH_GAIN;
            end
            PH_GAIN: begin
              mcand_d   = {{(ACC_W-DATA_W-16){prev_out_q[DATA_W-1]}}, prev_out_q, 16'b0};
              mplier_d  = {1'b0, lag_time_q};
              bcnt_d    = BCNT_W'(TIME_W);
              sub_d     = 1'b0;
              msb_neg_d = 1'b0;
              phase_d   = PH_LAG;
            end
            PH_LAG: begin
              state_d = ST_ABS;
            end
            default: begin
              state_d = ST_ABS;
            end
          endcase
        end
      end

      ST_ABS: begin
        neg_d   = acc_q[ACC_W-1];
        acc_d   = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;
        state_d = ST_ROUND;
      end

      ST_ROUND: begin
        acc_d   = acc_q + ACC_W'(den_q >> 1);
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        // A quotient of 2^32 or more shows as a high part not below the divisor.
        ovf_d   = (acc_q[ACC_W-1:DATA_W] >= (ACC_W-DATA_W)'(den_q));
        rem_d   = acc_q[DATA_W +: DEN_W];
        quo_d   = acc_q[DATA_W-1:0];
        bcnt_d  = BCNT_W'(DATA_W);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        rem_d  = rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        quo_d  = {quo_q[DATA_W-2:0], rem_ge};
        bcnt_d = bcnt_q - BCNT_W'(1);
        if (last_bit) begin
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = calc_q ? sat_val : byp_q;
          out_en_d    = en_q;
          out_tick_d  = TICK_W'(cnt_q);
          prev_out_d  = calc_q ? sat_val : byp_q;
          prev_in_d   = u_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_LEAD;
      bcnt_q        <= '0;
      out_valid_q   <= 1'b0;
      prev_in_q     <= '0;
      prev_out_q    <= '0;
      cnt_q         <= '0;
      lag_time_q    <= '0;
      lead_time_q   <= '0;
      gain_q        <= GAIN_RESET;
      period_q      <= DEFAULT_PERIOD_US;
      reset_value_q <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
      prev_in_q   <= prev_in_d;
      prev_out_q  <= prev_out_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LAG_TIME:    lag_time_q    <= cfg_data_i;
          CFG_LEAD_TIME:   lead_time_q   <= cfg_data_i;
          CFG_GAIN:        gain_q        <= cfg_data_i[GAIN_W-1:0];
          CFG_PERIOD:      period_q      <= cfg_data_i;
          CFG_RESET_VALUE: reset_value_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    en_q       <= en_d;
    calc_q     <= calc_d;
    byp_q      <= byp_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    sub_q      <= sub_d;
    msb_neg_q  <= msb_neg_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    ovf_q      <= ovf_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_q      <= out_d;
    out_en_q   <= out_en_d;
    out_tick_q <= out_tick_d;
  end

  assign out_valid_o   = out_valid_q;
  assign filter_out_o  = out_q;
  assign enabled_out_o = out_en_q;
  assign tick_count_o  = out_tick_q;

endmodule

FILE: tb/lead_lag_first_order_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the lead-lag filter: directed corners, random ticks, scoreboard.
module lead_lag_first_order_filter_tb;
  import lllf_pkg::*;

  // The run is ended as failed if it is still going after this many cycles. Even with
  // every tick enabled and both sides idling, the whole run needs only a fraction of this.
  localparam int unsigned LIMIT_CYCLES     = 3_000_000;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int unsigned LONG_HOLD_CYCLES = 1200;
  // Quiet time after the last result, a bit more than the latency of an enabled tick.
  localparam int unsigned SETTLE_CYCLES    = 200;
  // Ticks per random phase; eight phases plus the directed part make about 1950.
  localparam int unsigned PHASE_TICKS      = 240;

  // One copy of the five configuration registers.
  typedef struct packed {
    logic [TIME_W-1:0]        lag;
    logic [TIME_W-1:0]        lead;
    logic signed [GAIN_W-1:0] gain;
    logic [TIME_W-1:0]        period;
    logic signed [DATA_W-1:0] hold_value;
  } filter_settings_t;

  // What one tick produces on the output channel.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     enabled;
    logic [TICK_W-1:0]        tick;
  } tick_result_t;

  // Tracks the filter state, predicts every tick and checks the results in order.
  class lead_lag_tracker;
    filter_settings_t         settings;
    logic signed [DATA_W-1:0] last_in;
    logic signed [DATA_W-1:0] last_out;
    int unsigned              ticks;
    tick_result_t             pending_ticks[$];
    int unsigned              error_count;

    function new();
      settings.lag        = '0;
      settings.lead       = '0;
      settings.gain       = GAIN_RESET;
      // The period register comes out of reset at one second.
      settings.period     = DEFAULT_PERIOD_US;
      settings.hold_value = '0;
      last_in     = '0;
      last_out    = '0;
      ticks       = 0;
      error_count = 0;
    endfunction

    function void apply_setting(cfg_idx_e idx, logic [DATA_W-1:0] d);
      case (idx)
        CFG_LAG_TIME:    settings.lag        = d;
        CFG_LEAD_TIME:   settings.lead       = d;
        CFG_GAIN:        settings.gain       = d[GAIN_W-1:0];
        CFG_PERIOD:      settings.period     = d;
        CFG_RESET_VALUE: settings.hold_value = d;
        default: ;
      endcase
    endfunction

    // Exact lead-lag step: the numerator is formed in 128-bit signed arithmetic,
    // divided by (T+T1)*2^16 with rounding half away from zero, then saturated.
    function logic signed [DATA_W-1:0] filtered_value(logic signed [DATA_W-1:0] u);
      logic signed [127:0] t_per, t_lag, t_lead, kp, v_old, u_old, u_now, num;
      logic [127:0]        mag, den, quo;
      logic                neg;
      t_per  = (settings.period == '0) ? DEFAULT_PERIOD_US : settings.period;
      t_lag  = settings.lag;
      t_lead = settings.lead;
      kp     = settings.gain;
      v_old  = last_out;
      u_old  = last_in;
      u_now  = u;
      num = ((t_lag * v_old) <<< 16) + kp * (t_per + t_lead) * u_now - kp * t_lead * u_old;
      neg = num[127];
      mag = neg ? -num : num;
      den = 128'(t_per + t_lag) << 16;
      quo = (mag + (den >> 1)) / den;
      if (neg) begin
        return (quo >= 128'h8000_0000) ? SAT_MIN : -quo[DATA_W-1:0];
      end
      return (quo > 128'h7FFF_FFFF) ? SAT_MAX : quo[DATA_W-1:0];
    endfunction

    function void note_tick(logic signed [DATA_W-1:0] u, logic en, logic hr);
      tick_result_t r;
      // A disabled tick repeats the last output and ignores the reset flag.
      r.value = last_out;
      if (en) begin
        r.value = hr ? settings.hold_value : filtered_value(u);
      end
      last_in  = u;
      last_out = r.value;
      ticks    = (ticks + 1) % COUNT_MODULUS;
      r.enabled = en;
      r.tick    = TICK_W'(ticks);
      pending_ticks.push_back(r);
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t want;
      if (pending_ticks.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: result with no tick outstanding: out=%0d en=%0b count=%0d",
                   $time, got.value, got.enabled, got.tick);
        end
        return;
      end
      want = pending_ticks.pop_front();
      if (got.value !== want.value || got.enabled !== want.enabled || got.tick !== want.tick)
      begin
        error_count++;
        if (error_count <= 10) begin
          $display("%0t: mismatch: out %0d/%0d en %0b/%0b count %0d/%0d (expected/actual)",
                   $time, want.value, got.value, want.enabled, got.enabled,
                   want.tick, got.tick);
        end
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [DATA_W-1:0]        cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] sample_in_i;
  logic                     enable_i;
  logic                     hold_reset_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] filter_out_o;
  logic                     enabled_out_o;
  logic [TICK_W-1:0]        tick_count_o;

  lead_lag_tracker sb;

  // Idle percentages for the two sides, and the handshake that asks the receiver
  // process for one long hold-off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned holds_served;

  lead_lag_first_order_filter uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .sample_in_i,
    .enable_i,
    .hold_reset_i,
    .out_valid_o,
    .out_ready_i,
    .filter_out_o,
    .enabled_out_o,
    .tick_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both channels are sampled at the rising edge. The stimulus only changes through
  // nonblocking assignments, so the values seen here are the ones the block saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_tick({filter_out_o, enabled_out_o, tick_count_o});
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_tick(sample_in_i, enable_i, hold_reset_i);
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off counted here when one is asked.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    holds_served = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("lead_lag_first_order_filter_tb: errors");
    $finish;
  end

  // Offers one tick after a random gap and returns at the edge of its transfer. Valid is
  // left high so that a following tick with no gap keeps it up without a glitch.
  task automatic send_tick(input logic signed [DATA_W-1:0] u, input logic en, input logic hr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_in_i  <= u;
    enable_i     <= en;
    hold_reset_i <= hr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has been transferred. The
  // first edge lets the monitor record the last input transfer before the count is read.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    sb.apply_setting(idx, d);
    @(posedge clk_i);
  endtask

  // Writes all five registers back to back; only called while the block is idle.
  task automatic load_settings(input filter_settings_t s);
    write_reg(CFG_LAG_TIME, s.lag);
    write_reg(CFG_LEAD_TIME, s.lead);
    // The bits above the gain field are don't-care, so they get random values.
    write_reg(CFG_GAIN, {(DATA_W-GAIN_W)'($urandom), s.gain});
    write_reg(CFG_PERIOD, s.period);
    write_reg(CFG_RESET_VALUE, s.hold_value);
    cfg_we_i <= 1'b0;
  endtask

  function automatic filter_settings_t make_settings(
    input logic [TIME_W-1:0] lag, input logic [TIME_W-1:0] lead,
    input logic signed [GAIN_W-1:0] gain, input logic [TIME_W-1:0] period,
    input logic signed [DATA_W-1:0] hold_value);
    filter_settings_t s;
    s.lag        = lag;
    s.lead       = lead;
    s.gain       = gain;
    s.period     = period;
    s.hold_value = hold_value;
    return s;
  endfunction

  function automatic logic [31:0] corner_or_any(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(2))
      0:       return lo;
      1:       return hi;
      default: return $urandom;
    endcase
  endfunction

  // Style 0 is a plausible plant setup whose output stays in range most of the time,
  // style 1 is fully random, and any other style mixes the register extremes.
  function automatic filter_settings_t random_settings(input int unsigned style);
    filter_settings_t s;
    case (style)
      0: begin
        s.period     = $urandom_range(100000, 1000);
        s.lag        = $urandom_range(5 * s.period, 0);
        s.lead       = $urandom_range(2 * s.period, 0);
        s.gain       = GAIN_W'($urandom_range(4 * 65536, 0) - 2 * 65536);
        s.hold_value = $urandom;
      end
      1: begin
        s.lag        = $urandom;
        s.lead       = $urandom;
        s.gain       = GAIN_W'($urandom);
        s.period     = ($urandom_range(3) == 0) ? '0 : $urandom;
        s.hold_value = $urandom;
      end
      default: begin
        s.lag        = corner_or_any('0, '1);
        s.lead       = corner_or_any('0, '1);
        s.gain       = GAIN_W'(corner_or_any(32'hFF80_0000, 32'h007F_FFFF));
        // The low corner of the period is zero, which the block reads as one second.
        s.period     = corner_or_any('0, '1);
        s.hold_value = corner_or_any(SAT_MIN, SAT_MAX);
      end
    endcase
    return s;
  endfunction

  // Half the samples stay within +/-16.0 so that the recursion runs without saturating.
  function automatic logic [DATA_W-1:0] random_input();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(32'h0020_0000, 0) - 32'h0010_0000;
      5, 6, 7:       return $urandom;
      default: begin
        case ($urandom_range(3))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // One random phase: new settings, an idle pattern, optionally a long receiver
  // hold-off at its start, then mostly enabled ticks with an occasional reset tick.
  task automatic run_random_phase(input filter_settings_t s, input int unsigned s_idle,
                                  input int unsigned r_idle, input bit long_hold,
                                  input int unsigned count);
    load_settings(s);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (long_hold) begin
      hold_requests++;
    end
    repeat (count) begin
      send_tick(random_input(), $urandom_range(99) < 85, $urandom_range(99) < 8);
    end
    drain();
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_LAG_TIME;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    sample_in_i  <= '0;
    enable_i     <= 1'b0;
    hold_reset_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings give a unity pass-through, so the sample extremes come straight
    // back. A disabled tick must hold the output even with the reset flag up.
    send_tick(0, 1'b1, 1'b0);
    send_tick(SAT_MAX, 1'b1, 1'b0);
    send_tick(SAT_MIN, 1'b1, 1'b0);
    send_tick(1, 1'b1, 1'b0);
    send_tick(-1, 1'b1, 1'b0);
    send_tick(32'h1234_5678, 1'b0, 1'b1);
    send_tick(32'h0003_0000, 1'b1, 1'b1);
    send_tick(32'hDEAD_BEEF, 1'b0, 1'b0);
    drain();

    // Longest time constants, the most negative gain and a zero period. Starting from
    // the largest reset value puts the biggest previous output into the lag term.
    load_settings(make_settings('1, '1, 24'h80_0000, '0, SAT_MAX));
    send_tick(0, 1'b1, 1'b1);
    send_tick(SAT_MAX, 1'b1, 1'b0);
    send_tick(SAT_MIN, 1'b1, 1'b0);
    send_tick(0, 1'b1, 1'b0);
    send_tick(32'h5555_5555, 1'b0, 1'b1);
    send_tick(32'hAAAA_AAAA, 1'b1, 1'b0);
    drain();

    // No lag or lead, the largest gain and the longest period: saturation both ways.
    load_settings(make_settings('0, '0, 24'h7F_FFFF, '1, SAT_MIN));
    send_tick(1, 1'b1, 1'b1);
    send_tick(SAT_MAX, 1'b1, 1'b0);
    send_tick(SAT_MIN, 1'b1, 1'b0);
    send_tick(32'h0001_0000, 1'b1, 1'b0);
    send_tick(32'hFFFF_0000, 1'b1, 1'b0);
    drain();

    // A gain of one half makes odd samples land exactly halfway between two outputs,
    // which must round away from zero for both signs.
    load_settings(make_settings('0, '0, 24'h00_8000, 3, '0));
    send_tick(1, 1'b1, 1'b0);
    send_tick(-1, 1'b1, 1'b0);
    send_tick(3, 1'b1, 1'b0);
    send_tick(-3, 1'b1, 1'b0);
    drain();

    // Random phases: the sender idles lightly and the receiver heavily, then the other
    // way round, then nobody idles. Phases 1 and 6 open with a long receiver hold-off.
    for (int p = 0; p < 8; p++) begin
      run_random_phase(random_settings(p % 3),
                       (p < 3) ? 15 : ((p < 6) ? 58 : 0),
                       (p < 3) ? 58 : ((p < 6) ? 15 : 0),
                       (p == 1) || (p == 6), PHASE_TICKS);
    end

    // Anything that shows up now has no tick behind it and counts as an error.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending_ticks.size() == 0) begin
      $display("lead_lag_first_order_filter_tb: clean");
    end else begin
      $display("lead_lag_first_order_filter_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lllf_pkg.sv
hw/rtl/lead_lag_first_order_filter.sv
tb/lead_lag_first_order_filter_tb.sv
